// ===== rtl/wols_pkg.sv =====
// Shared types and constants for the write-once log store.
package wols_pkg;

    localparam int IDX_W      = 10;
    localparam int EPOCH_W    = 32;
    localparam int PAYLOAD_W  = 64;
    localparam int ID_W       = 8;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_READ   = 2'd1,
        MODE_TRIM   = 2'd2,
        MODE_SEAL   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        RPL_ACK       = 3'd0,
        RPL_SEALED    = 3'd1,
        RPL_DELETED   = 3'd2,
        RPL_WRITTEN   = 3'd3,
        RPL_UNWRITTEN = 3'd4,
        RPL_CONTENTS  = 3'd5
    } rpl_t;

    localparam logic [1:0] ENT_UNWRITTEN = 2'd0;
    localparam logic [1:0] ENT_WRITTEN   = 2'd1;
    localparam logic [1:0] ENT_DELETED   = 2'd2;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic reduce_step;
        logic read_en;
        logic exec;
    } wols_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic mod_needed;
        logic reduce_done;
        logic out_free;
    } wols_sts_t;

endpackage

// ===== rtl/write_once_log_store_epoch.sv =====
// Write-once log store: append/read/trim/seal over a status table, a data table and an epoch.
// Flow: a transferred request is captured, reduced modulo LOG_DEPTH when LOG_DEPTH < 1024,
//   read from the tables and executed into the reply register; execute waits while the
//   previous reply is still held. The next request is taken only after execute, since the
//   table read and the execute/write of a request are separate states.
// Reset: epoch and reply valid clear at once; a clearing pass then writes every status
//   entry unwritten with s_axis_tready low. Data table is not cleared.
module write_once_log_store_epoch
    import wols_pkg::*;
#(
    parameter int LOG_DEPTH  = 1024,
    parameter int DATA_WIDTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // index, epoch, payload, client_id, thread_tag, zero pad
    input  logic [127:0] s_axis_tdata,
    // mode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // contents, reply_client, reply_thread
    output logic [79:0]  m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser
);

    wols_cmd_t            cmd;
    wols_sts_t            sts;
    logic [PAYLOAD_W-1:0] out_contents;
    logic [ID_W-1:0]      out_client;
    logic [ID_W-1:0]      out_thread;

    wols_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wols_dpath #(
        .LOG_DEPTH  (LOG_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_mode      (s_axis_tuser),
        .in_index     (s_axis_tdata[9:0]),
        .in_epoch     (s_axis_tdata[41:10]),
        .in_payload   (s_axis_tdata[105:42]),
        .in_client    (s_axis_tdata[113:106]),
        .in_thread    (s_axis_tdata[121:114]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_status   (m_axis_tuser),
        .out_contents (out_contents),
        .out_client   (out_client),
        .out_thread   (out_thread)
    );

    assign m_axis_tdata = {out_thread, out_client, out_contents};

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= RPL_CONTENTS))
        else $error("reply status out of range");

    a_contents_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != RPL_WRITTEN && m_axis_tuser != RPL_CONTENTS)
        |-> (m_axis_tdata[63:0] == '0))
        else $error("contents nonzero on a reply without data");

endmodule

// ===== rtl/wols_ctrl.sv =====
// Sequencer: clearing pass, request capture, index reduction, table read, execute.
module wols_ctrl
    import wols_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  wols_sts_t sts,
    output wols_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_REDUCE = 5'b00100,
        S_READ   = 5'b01000,
        S_EXEC   = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.mod_needed ? S_REDUCE : S_READ;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (sts.reduce_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                // hold until the reply register can take a new transfer
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/wols_dpath.sv =====
// Datapath: request registers, index reduction, status/data tables, epoch, reply register.
module wols_dpath
    import wols_pkg::*;
#(
    parameter int LOG_DEPTH  = 1024,
    parameter int DATA_WIDTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wols_cmd_t            cmd,
    output wols_sts_t            sts,
    input  logic [1:0]           in_mode,
    input  logic [IDX_W-1:0]     in_index,
    input  logic [EPOCH_W-1:0]   in_epoch,
    input  logic [PAYLOAD_W-1:0] in_payload,
    input  logic [ID_W-1:0]      in_client,
    input  logic [ID_W-1:0]      in_thread,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [2:0]           out_status,
    output logic [PAYLOAD_W-1:0] out_contents,
    output logic [ID_W-1:0]      out_client,
    output logic [ID_W-1:0]      out_thread
);

    localparam int AW = $clog2(LOG_DEPTH);

    // captured request
    mode_t                 mode_reg;
    logic [IDX_W-1:0]      rem_reg;
    logic [IDX_W-1:0]      rem_step;
    logic [EPOCH_W-1:0]    epoch_reg;
    logic [DATA_WIDTH-1:0] payload_reg;
    logic [ID_W-1:0]       client_reg;
    logic [ID_W-1:0]       thread_reg;

    logic [AW-1:0]         addr;
    logic [AW-1:0]         clr_addr_reg;
    logic                  reduce_done;
    logic                  mod_needed;

    // tables
    logic [1:0]            stat_mem [LOG_DEPTH];
    logic [DATA_WIDTH-1:0] data_mem [LOG_DEPTH];
    logic [1:0]            stat_rd_reg;
    logic [DATA_WIDTH-1:0] data_rd_reg;
    logic                  stat_we;
    logic [AW-1:0]         stat_wa;
    logic [1:0]            stat_wd;

    logic [EPOCH_W-1:0]    sealed_epoch_reg;
    logic                  seal_upd;

    // execute results
    logic                  rpl_valid;
    rpl_t                  rpl_code;
    logic                  rpl_with_data;
    logic                  exe_stat_we;
    logic [1:0]            exe_stat_wd;
    logic                  data_we;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    rpl_t                  out_status_reg;
    logic [PAYLOAD_W-1:0]  out_contents_reg;
    logic [ID_W-1:0]       out_client_reg;
    logic [ID_W-1:0]       out_thread_reg;

    // index modulo LOG_DEPTH: quotient by reciprocal multiply, remainder written back by the reduction step
    generate
        if (LOG_DEPTH < (1 << IDX_W))
        begin : g_mod
            localparam int DW = $clog2(LOG_DEPTH);
            localparam int SH = IDX_W + DW;
            localparam int RW = IDX_W + 2;
            // (x * RECIP) >> SH equals x / LOG_DEPTH for every IDX_W-bit x
            localparam logic [RW-1:0]    RECIP =
                RW'(((64'd1 << SH) + LOG_DEPTH - 1) / LOG_DEPTH);
            localparam logic [IDX_W-1:0] DEP   = IDX_W'(LOG_DEPTH);

            logic [IDX_W+RW-1:0] prod;
            logic [IDX_W-1:0]    quot;

            assign prod     = rem_reg * RECIP;
            assign quot     = IDX_W'(prod >> SH);
            assign rem_step = rem_reg - IDX_W'(quot * DEP);

            assign reduce_done = 1'b1;
            assign mod_needed  = 1'b1;
        end
        else
        begin : g_nomod
            assign rem_step    = rem_reg;
            assign reduce_done = 1'b1;
            assign mod_needed  = 1'b0;
        end
    endgenerate

    assign addr = AW'(rem_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode_t'(in_mode);
            rem_reg     <= in_index;
            epoch_reg   <= in_epoch;
            payload_reg <= in_payload[DATA_WIDTH-1:0];
            client_reg  <= in_client;
            thread_reg  <= in_thread;
        end
        else if (cmd.reduce_step)
        begin
            rem_reg <= rem_step;
        end
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // request execution
    always_comb
    begin
        rpl_valid     = 1'b0;
        rpl_code      = RPL_ACK;
        rpl_with_data = 1'b0;
        exe_stat_we   = 1'b0;
        exe_stat_wd   = ENT_WRITTEN;
        data_we       = 1'b0;
        seal_upd      = 1'b0;
        case (mode_reg)
            MODE_APPEND:
            begin
                rpl_valid = 1'b1;
                if (epoch_reg != sealed_epoch_reg)
                begin
                    rpl_code = RPL_SEALED;
                end
                else if (stat_rd_reg == ENT_DELETED)
                begin
                    rpl_code = RPL_DELETED;
                end
                else if (stat_rd_reg == ENT_WRITTEN)
                begin
                    rpl_code      = RPL_WRITTEN;
                    rpl_with_data = 1'b1;
                end
                else
                begin
                    rpl_code    = RPL_ACK;
                    exe_stat_we = 1'b1;
                    exe_stat_wd = ENT_WRITTEN;
                    data_we     = 1'b1;
                end
            end
            MODE_READ:
            begin
                rpl_valid = 1'b1;
                if (epoch_reg != sealed_epoch_reg)
                begin
                    rpl_code = RPL_SEALED;
                end
                else if (stat_rd_reg == ENT_WRITTEN)
                begin
                    rpl_code      = RPL_CONTENTS;
                    rpl_with_data = 1'b1;
                end
                else if (stat_rd_reg == ENT_DELETED)
                begin
                    rpl_code = RPL_DELETED;
                end
                else
                begin
                    rpl_code = RPL_UNWRITTEN;
                end
            end
            MODE_TRIM:
            begin
                if (stat_rd_reg != ENT_UNWRITTEN)
                begin
                    rpl_valid   = 1'b1;
                    rpl_code    = RPL_ACK;
                    exe_stat_we = 1'b1;
                    exe_stat_wd = ENT_DELETED;
                end
            end
            MODE_SEAL:
            begin
                seal_upd = (epoch_reg > sealed_epoch_reg);
            end
            default:
            begin
                rpl_valid = 1'b0;
            end
        endcase
    end

    assign stat_we = cmd.clear_en | (cmd.exec & exe_stat_we);
    assign stat_wa = cmd.clear_en ? clr_addr_reg : addr;
    assign stat_wd = cmd.clear_en ? ENT_UNWRITTEN : exe_stat_wd;

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_wa] <= stat_wd;
        end
        if (cmd.read_en)
        begin
            stat_rd_reg <= stat_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && data_we)
        begin
            data_mem[addr] <= payload_reg;
        end
        if (cmd.read_en)
        begin
            data_rd_reg <= data_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sealed_epoch_reg <= '0;
        end
        else if (cmd.exec && seal_upd)
        begin
            sealed_epoch_reg <= epoch_reg;
        end
    end

    // reply register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec && rpl_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && rpl_valid)
        begin
            out_status_reg   <= rpl_code;
            out_contents_reg <= rpl_with_data ? PAYLOAD_W'(data_rd_reg) : '0;
            out_client_reg   <= client_reg;
            out_thread_reg   <= thread_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_contents = out_contents_reg;
    assign out_client   = out_client_reg;
    assign out_thread   = out_thread_reg;

    assign sts.clear_done  = (clr_addr_reg == AW'(LOG_DEPTH - 1));
    assign sts.mod_needed  = mod_needed;
    assign sts.reduce_done = reduce_done;
    assign sts.out_free    = ~out_valid_reg | out_ready;

endmodule

// ===== tb/tb.sv =====
// Testbench for the write-once log store: directed and random requests, checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import wols_pkg::*;

    localparam int LIMIT       = 400000;
    localparam int RANDOM_REQS = 1500;
    localparam int DEPTH       = 1024;

    typedef struct packed {
        rpl_t             status;
        logic [63:0]      contents;
        logic [ID_W-1:0]  client;
        logic [ID_W-1:0]  thread;
    } reply_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    // predictor state
    logic [1:0]           entry_state [DEPTH];
    logic [63:0]          entry_word  [DEPTH];
    logic [EPOCH_W-1:0]   cur_epoch;
    reply_t               pending_replies [$];

    int mismatches;
    int cycles;
    int burst_left;
    int stall_left;
    int stall_mode;

    write_once_log_store_epoch dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Applies one accepted request to the log image and queues the reply it causes, if any.
    function automatic void predict_reply(input mode_t m, input logic [IDX_W-1:0] idx,
                                          input logic [EPOCH_W-1:0] ep,
                                          input logic [63:0] pay,
                                          input logic [ID_W-1:0] cli,
                                          input logic [ID_W-1:0] thr);
        reply_t r;
        r.status   = RPL_ACK;
        r.contents = '0;
        r.client   = cli;
        r.thread   = thr;
        case (m)
            MODE_APPEND:
            begin
                if (ep != cur_epoch)
                    r.status = RPL_SEALED;
                else if (entry_state[idx] == ENT_DELETED)
                    r.status = RPL_DELETED;
                else if (entry_state[idx] == ENT_WRITTEN)
                begin
                    r.status   = RPL_WRITTEN;
                    r.contents = entry_word[idx];
                end
                else
                begin
                    entry_word[idx]  = pay;
                    entry_state[idx] = ENT_WRITTEN;
                end
                pending_replies.push_back(r);
            end
            MODE_READ:
            begin
                if (ep != cur_epoch)
                    r.status = RPL_SEALED;
                else if (entry_state[idx] == ENT_WRITTEN)
                begin
                    r.status   = RPL_CONTENTS;
                    r.contents = entry_word[idx];
                end
                else if (entry_state[idx] == ENT_DELETED)
                    r.status = RPL_DELETED;
                else
                    r.status = RPL_UNWRITTEN;
                pending_replies.push_back(r);
            end
            MODE_TRIM:
            begin
                // trim of a never-written entry is silent
                if (entry_state[idx] != ENT_UNWRITTEN)
                begin
                    entry_state[idx] = ENT_DELETED;
                    pending_replies.push_back(r);
                end
            end
            default:
            begin
                if (ep > cur_epoch)
                    cur_epoch = ep;
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input mode_t m, input logic [IDX_W-1:0] idx,
                            input logic [EPOCH_W-1:0] ep, input logic [63:0] pay,
                            input logic [ID_W-1:0] cli, input logic [ID_W-1:0] thr);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= {6'd0, thr, cli, pay, ep, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_reply(m, idx, ep, pay, cli, thr);
        @(negedge clk);
    endtask

    // Sender holds off until every outstanding reply has been seen.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_append_read();
        send_req(MODE_READ,   10'd1023, 32'd0, 64'd0, 8'd0, 8'd0);
        send_req(MODE_APPEND, 10'd0, 32'd0, '1, 8'd255, 8'd255);
        send_req(MODE_APPEND, 10'd0, 32'd0, 64'd0, 8'd1, 8'd2);
        send_req(MODE_READ,   10'd0, 32'd0, 64'd0, 8'd3, 8'd4);
        send_req(MODE_APPEND, 10'd1023, 32'd0, 64'd0, 8'd5, 8'd6);
        send_req(MODE_READ,   10'd1023, 32'd0, '1, 8'd7, 8'd8);
        send_req(MODE_APPEND, 10'd5, 32'd1, 64'h1234, 8'd9, 8'd10);
        send_req(MODE_READ,   10'd0, '1, 64'd0, 8'd11, 8'd12);
        drain_replies();
    endtask

    task automatic test_trim();
        send_req(MODE_TRIM,   10'd7, 32'd0, 64'd0, 8'd20, 8'd21);
        send_req(MODE_TRIM,   10'd0, 32'hdead_beef, 64'd0, 8'd22, 8'd23);
        send_req(MODE_TRIM,   10'd0, 32'd0, 64'd0, 8'd24, 8'd25);
        send_req(MODE_APPEND, 10'd0, 32'd0, 64'h55, 8'd26, 8'd27);
        send_req(MODE_READ,   10'd0, 32'd0, 64'd0, 8'd28, 8'd29);
        drain_replies();
    endtask

    task automatic test_seal();
        send_req(MODE_SEAL,   10'd0, 32'd9, 64'd0, 8'd30, 8'd31);
        send_req(MODE_SEAL,   10'd0, 32'd4, 64'd0, 8'd32, 8'd33);
        send_req(MODE_SEAL,   10'd0, 32'd9, 64'd0, 8'd34, 8'd35);
        send_req(MODE_READ,   10'd1023, 32'd9, 64'd0, 8'd36, 8'd37);
        send_req(MODE_APPEND, 10'd2, 32'd0, 64'd0, 8'd38, 8'd39);
        drain_replies();
    endtask

    task automatic test_random();
        mode_t              m;
        logic [IDX_W-1:0]   idx;
        logic [EPOCH_W-1:0] ep;
        int                 pick;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                m = MODE_APPEND;
            else if (pick < 70)
                m = MODE_READ;
            else if (pick < 88)
                m = MODE_TRIM;
            else
                m = MODE_SEAL;
            // a small working set so entries cycle through all their states
            idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, DEPTH - 1))
                                              : IDX_W'($urandom_range(0, 47));
            if (m == MODE_SEAL)
                ep = ($urandom_range(0, 9) < 6) ? cur_epoch + $urandom_range(1, 4)
                                                : EPOCH_W'($urandom_range(0, cur_epoch));
            else if ($urandom_range(0, 99) < 85)
                ep = cur_epoch;
            else if ($urandom_range(0, 1) == 0)
                ep = $urandom();
            else
                ep = cur_epoch + 1;
            send_req(m, idx, ep, {$urandom(), $urandom()}, ID_W'($urandom_range(0, 255)),
                     ID_W'($urandom_range(0, 255)));
            if (n == RANDOM_REQS / 2)
                drain_replies();
        end
        drain_replies();
    endtask

    task automatic test_epoch_max();
        send_req(MODE_SEAL,   10'd0, '1, 64'd0, 8'd40, 8'd41);
        send_req(MODE_APPEND, 10'd1000, '1, 64'hfeed_0123_4567_89ab, 8'd42, 8'd43);
        send_req(MODE_SEAL,   10'd0, 32'd0, 64'd0, 8'd44, 8'd45);
        send_req(MODE_READ,   10'd1000, '1, 64'd0, 8'd46, 8'd47);
        drain_replies();
    endtask

    // reply checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
                note_mismatch("reply with none expected, status", 64'(m_axis_tuser), 64'd0);
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.status)
                    note_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                if (m_axis_tdata[63:0] !== want.contents)
                    note_mismatch("contents", m_axis_tdata[63:0], want.contents);
                if (m_axis_tdata[71:64] !== want.client)
                    note_mismatch("reply_client", 64'(m_axis_tdata[71:64]), 64'(want.client));
                if (m_axis_tdata[79:72] !== want.thread)
                    note_mismatch("reply_thread", 64'(m_axis_tdata[79:72]), 64'(want.thread));
            end
        end
    end

    // receiver backpressure: always ready, mostly ready, or mostly stalled, in stretches
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(32, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        cycles        = 0;
        burst_left    = 0;
        stall_left    = 0;
        stall_mode    = 0;
        cur_epoch     = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_state[i] = ENT_UNWRITTEN;
            entry_word[i]  = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_append_read();
        test_trim();
        test_seal();
        test_random();
        test_epoch_max();

        repeat (20) @(posedge clk);
        if (pending_replies.size() != 0)
            note_mismatch("replies never seen", 64'(pending_replies.size()), 64'd0);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
